>>> rtl/scope_capture_trigger_ring_assert.svh
// assertion macros for the capture rtl
`ifndef SCOPE_CAPTURE_TRIGGER_RING_ASSERT_SVH
`define SCOPE_CAPTURE_TRIGGER_RING_ASSERT_SVH

// implication checked every cycle outside reset
`define SCR_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define SCR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

>>> rtl/scr_pkg.sv
package scr_pkg;
   localparam int RingDepthDefault   = 1024;
   localparam int NumChannelsDefault = 4;

   localparam logic [2:0] KIND_SAMPLE = 3'd0;
   localparam logic [2:0] KIND_MANUAL = 3'd1;
   localparam logic [2:0] KIND_FAULT  = 3'd2;
   localparam logic [2:0] KIND_STATE  = 3'd3;
   localparam logic [2:0] KIND_ARM    = 3'd4;
   localparam logic [2:0] KIND_STOP   = 3'd5;
   localparam logic [2:0] KIND_READ   = 3'd6;

   localparam logic [2:0] TRIG_MANUAL    = 3'd1;
   localparam logic [2:0] TRIG_FAULT     = 3'd2;
   localparam logic [2:0] TRIG_STATE     = 3'd3;
   localparam logic [2:0] TRIG_THRESHOLD = 3'd4;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_ARMED    = 2'd1;
   localparam logic [1:0] ST_COMPLETE = 2'd2;
   localparam logic [1:0] ST_STOPPED  = 2'd3;

   localparam logic [2:0] RS_NONE    = 3'd0;
   localparam logic [2:0] RS_STOPPED = 3'd5;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_TRIG_KIND = 3'd1;
   localparam logic [2:0] REG_EDGE      = 3'd2;
   localparam logic [2:0] REG_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_MATCH     = 3'd4;
   localparam logic [2:0] REG_DECIM     = 3'd5;
   localparam logic [2:0] REG_PRE       = 3'd6;
   localparam logic [2:0] REG_POST      = 3'd7;

   // remainder unit handshake
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mod_ctl_type;
endpackage

>>> rtl/scr_mod_serial.sv
// bit-serial remainder of a 32-bit word by a 16-bit divisor, one bit a cycle
module scr_mod_serial (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic        zero_rem
);
   logic [31:0] shift_ff, shift_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   // shift one dividend bit into the partial remainder
   always_comb begin
      trial    = {rem_ff[15:0], shift_ff[31]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         rem_in   = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in   = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign zero_rem = (rem_ff == 17'd0);
endmodule

>>> rtl/scr_ring_mem.sv
// sample ring: one write and one read a cycle, registered read data
module scr_ring_mem #(
   parameter int RING_DEPTH   = scr_pkg::RingDepthDefault,
   parameter int NUM_CHANNELS = scr_pkg::NumChannelsDefault,
   localparam int AW = $clog2(RING_DEPTH),
   localparam int DW = 65 + 32 * NUM_CHANNELS
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem_ff [RING_DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> rtl/scope_capture_trigger_ring.sv
// a sample that reaches the remainder unit waits for the bit-serial remainder, then
// is written to the ring when kept; a read that returns a sample waits on the ring
// read port; other requests go straight to the response; one request in flight at a time
// the next request is taken only after the response is accepted
// the csr port is always ready; reset is synchronous active high and clears
// control state and registers; ring contents are undefined until written
module scope_capture_trigger_ring #(
   parameter int RING_DEPTH   = scr_pkg::RingDepthDefault,
   parameter int NUM_CHANNELS = scr_pkg::NumChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_sample_sequence,
   input  logic [31:0] req_sample_time,
   input  logic signed [31:0] req_trigger_value,
   input  logic [31:0] req_chan_a,
   input  logic [31:0] req_chan_b,
   input  logic [31:0] req_chan_c,
   input  logic [31:0] req_chan_d,
   input  logic [7:0]  req_task_state,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_capture_status,
   output logic [2:0]  rsp_final_reason,
   output logic [10:0] rsp_stored_count,
   output logic [31:0] rsp_overrun_count,
   output logic        rsp_read_valid,
   output logic        rsp_read_gap,
   output logic [31:0] rsp_read_sequence,
   output logic [31:0] rsp_read_time,
   output logic [31:0] rsp_read_a,
   output logic [31:0] rsp_read_b,
   output logic [31:0] rsp_read_c,
   output logic [31:0] rsp_read_d
);
   localparam int AW = $clog2(RING_DEPTH);
   localparam int DW = 65 + 32 * NUM_CHANNELS;
   localparam logic [31:0] Depth32 = 32'(RING_DEPTH);

   localparam logic [2:0] P_IDLE   = 3'd0;
   localparam logic [2:0] P_MOD    = 3'd1;
   localparam logic [2:0] P_SAMPLE = 3'd2;
   localparam logic [2:0] P_RDWAIT = 3'd3;
   localparam logic [2:0] P_RDDATA = 3'd4;
   localparam logic [2:0] P_RESP   = 3'd5;
   localparam logic [2:0] P_EXEC   = 3'd6;

   // configuration registers
   logic        mode_ff, edge_ff;
   logic [2:0]  tkind_ff;
   logic signed [31:0] thr_ff;
   logic [7:0]  match_ff;
   logic [15:0] decim_ff;
   logic [10:0] pre_ff, post_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         tkind_ff <= '0;
         edge_ff  <= 1'b0;
         thr_ff   <= '0;
         match_ff <= '0;
         decim_ff <= 16'd1;
         pre_ff   <= '0;
         post_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            scr_pkg::REG_MODE:      mode_ff  <= csr_data[0];
            scr_pkg::REG_TRIG_KIND: tkind_ff <= csr_data[2:0];
            scr_pkg::REG_EDGE:      edge_ff  <= csr_data[0];
            scr_pkg::REG_THRESHOLD: thr_ff   <= csr_data;
            scr_pkg::REG_MATCH:     match_ff <= csr_data[7:0];
            scr_pkg::REG_DECIM:     decim_ff <= csr_data[15:0];
            scr_pkg::REG_PRE:       pre_ff   <= csr_data[10:0];
            scr_pkg::REG_POST:      post_ff  <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // captured request
   logic [2:0]  kind_ff;
   logic [31:0] seq_ff, time_ff;
   logic signed [31:0] tval_ff;
   logic [31:0] cha_ff, chb_ff, chc_ff, chd_ff;
   logic [7:0]  ts_ff;

   // capture state
   logic [31:0] wr_ord_ff, rd_ord_ff, wstart_ff, overruns_ff, last_seq_ff;
   logic signed [31:0] prev_val_ff;
   logic [10:0] wcount_ff, post_left_ff;
   logic        have_last_ff, have_prev_ff, armed_ff, trig_ff, cursor_ff;
   logic [2:0]  pend_ff;
   logic [7:0]  last_ts_ff;
   logic [1:0]  status_ff;
   logic [2:0]  reason_ff;
   logic [2:0]  phase_ff;
   logic [31:0] cur_ff;

   // response register
   logic        rsp_valid_ff;
   logic        rv_ff, rg_ff;
   logic [31:0] rseq_ff, rtime_ff, ra_ff, rb_ff, rc_ff, rd_ff;

   // remainder unit
   scr_pkg::mod_ctl_type mod_ctl;
   logic mod_zero;

   scr_mod_serial u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_ctl.start),
      .dividend (seq_ff),
      .divisor  (decim_ff),
      .busy     (mod_ctl.busy),
      .done     (mod_ctl.done),
      .zero_rem (mod_zero)
   );

   // ring memory
   logic          mem_we;
   logic [DW-1:0] mem_wdata, mem_rdata;
   logic [AW-1:0] mem_raddr;
   logic [127:0]  chans;

   assign chans = {chd_ff, chc_ff, chb_ff, cha_ff};
   assign mem_wdata = {chans[32*NUM_CHANNELS-1:0], time_ff, seq_ff,
                       have_last_ff && ((seq_ff - last_seq_ff) != {16'd0, decim_ff})};
   assign mem_raddr = cur_ff[AW-1:0];
   assign mem_we    = (phase_ff == P_SAMPLE);

   scr_ring_mem #(
      .RING_DEPTH   (RING_DEPTH),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ord_ff[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready     = (phase_ff == P_IDLE) && !rsp_valid_ff;
   assign mod_ctl.start = (phase_ff == P_EXEC) && (kind_ff == scr_pkg::KIND_SAMPLE) &&
                          armed_ff && (decim_ff != 16'd0);

   // trigger evaluation for the sample under work
   logic        fire;
   logic [31:0] pre_eff, ord_next, win_n;
   logic [10:0] post_dec;
   always_comb begin
      case (tkind_ff)
         scr_pkg::TRIG_MANUAL:    fire = pend_ff[0];
         scr_pkg::TRIG_FAULT:     fire = pend_ff[1];
         scr_pkg::TRIG_STATE:     fire = pend_ff[2];
         scr_pkg::TRIG_THRESHOLD: fire = edge_ff ?
            (have_prev_ff && prev_val_ff > thr_ff && tval_ff <= thr_ff) :
            (have_prev_ff && prev_val_ff < thr_ff && tval_ff >= thr_ff);
         default: fire = 1'b0;
      endcase
      pre_eff = {21'd0, pre_ff};
      if (pre_eff > Depth32 - 32'd1) pre_eff = Depth32 - 32'd1;
      if (pre_eff > wr_ord_ff) pre_eff = wr_ord_ff;
      ord_next = wr_ord_ff + 32'd1;
      win_n    = ord_next - (trig_ff ? wstart_ff : (wr_ord_ff - pre_eff));
      post_dec = trig_ff ? post_left_ff : post_ff;
      if (post_dec != 11'd0) post_dec = post_dec - 11'd1;
   end

   // read cursor after catch-up
   logic [31:0] cur_start, cur_fix;
   always_comb begin
      cur_start = (status_ff == scr_pkg::ST_COMPLETE && !cursor_ff) ? wstart_ff : rd_ord_ff;
      cur_fix   = ((wr_ord_ff - cur_start) > Depth32) ? wr_ord_ff - Depth32 : cur_start;
   end

   // phase after the execute step
   logic       rd_ok;
   logic [2:0] exec_next;
   always_comb begin
      rd_ok = (status_ff != scr_pkg::ST_IDLE) &&
              !(mode_ff && status_ff != scr_pkg::ST_COMPLETE);
      exec_next = P_RESP;
      if (kind_ff == scr_pkg::KIND_SAMPLE && armed_ff && decim_ff != 16'd0)
         exec_next = P_MOD;
      if (kind_ff == scr_pkg::KIND_READ && rd_ok && wr_ord_ff != cur_fix)
         exec_next = P_RDWAIT;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_ord_ff    <= '0;
         rd_ord_ff    <= '0;
         wstart_ff    <= '0;
         wcount_ff    <= '0;
         overruns_ff  <= '0;
         post_left_ff <= '0;
         last_seq_ff  <= '0;
         have_last_ff <= 1'b0;
         prev_val_ff  <= '0;
         have_prev_ff <= 1'b0;
         pend_ff      <= '0;
         last_ts_ff   <= '0;
         armed_ff     <= 1'b0;
         trig_ff      <= 1'b0;
         cursor_ff    <= 1'b0;
         status_ff    <= scr_pkg::ST_IDLE;
         reason_ff    <= scr_pkg::RS_NONE;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (phase_ff)
            P_IDLE: begin
               if (req_valid && req_ready) begin
                  kind_ff <= req_kind;
                  seq_ff  <= req_sample_sequence;
                  time_ff <= req_sample_time;
                  tval_ff <= req_trigger_value;
                  cha_ff  <= req_chan_a;
                  chb_ff  <= req_chan_b;
                  chc_ff  <= req_chan_c;
                  chd_ff  <= req_chan_d;
                  ts_ff   <= req_task_state;
                  rv_ff   <= 1'b0;
                  phase_ff <= P_EXEC;
               end
            end
            P_EXEC: begin
               phase_ff <= exec_next;
               case (kind_ff)
                  scr_pkg::KIND_SAMPLE: ;
                  scr_pkg::KIND_MANUAL: begin
                     if (armed_ff && tkind_ff == scr_pkg::TRIG_MANUAL) pend_ff[0] <= 1'b1;
                  end
                  scr_pkg::KIND_FAULT: begin
                     if (armed_ff) pend_ff[1] <= 1'b1;
                  end
                  scr_pkg::KIND_STATE: begin
                     if (ts_ff != last_ts_ff && tkind_ff == scr_pkg::TRIG_STATE &&
                         ts_ff == match_ff) pend_ff[2] <= 1'b1;
                     last_ts_ff <= ts_ff;
                  end
                  scr_pkg::KIND_ARM: begin
                     wr_ord_ff    <= '0;
                     rd_ord_ff    <= '0;
                     wstart_ff    <= '0;
                     wcount_ff    <= '0;
                     overruns_ff  <= '0;
                     post_left_ff <= '0;
                     last_seq_ff  <= '0;
                     have_last_ff <= 1'b0;
                     prev_val_ff  <= '0;
                     have_prev_ff <= 1'b0;
                     pend_ff      <= '0;
                     armed_ff     <= 1'b1;
                     trig_ff      <= 1'b0;
                     cursor_ff    <= 1'b0;
                     status_ff    <= scr_pkg::ST_ARMED;
                     reason_ff    <= scr_pkg::RS_NONE;
                  end
                  scr_pkg::KIND_STOP: begin
                     armed_ff  <= 1'b0;
                     status_ff <= scr_pkg::ST_STOPPED;
                     reason_ff <= scr_pkg::RS_STOPPED;
                  end
                  scr_pkg::KIND_READ: begin
                     if (rd_ok) begin
                        if (status_ff == scr_pkg::ST_COMPLETE) cursor_ff <= 1'b1;
                        cur_ff <= cur_fix;
                        if (wr_ord_ff == cur_fix) rd_ord_ff <= cur_fix;
                     end
                  end
                  default: ;
               endcase
            end
            P_MOD: begin
               if (mod_ctl.done) begin
                  phase_ff <= mod_zero ? P_SAMPLE : P_RESP;
               end
            end
            P_SAMPLE: begin
               if (!mode_ff && (wr_ord_ff - rd_ord_ff) >= Depth32)
                  overruns_ff <= overruns_ff + 32'd1;
               wr_ord_ff    <= ord_next;
               last_seq_ff  <= seq_ff;
               have_last_ff <= 1'b1;
               if (mode_ff && !trig_ff && tkind_ff == scr_pkg::TRIG_THRESHOLD) begin
                  prev_val_ff  <= tval_ff;
                  have_prev_ff <= 1'b1;
               end
               if (!mode_ff) begin
                  wcount_ff <= (wr_ord_ff >= Depth32 - 32'd1) ? 11'(RING_DEPTH) :
                               11'(ord_next);
               end else if (trig_ff || fire) begin
                  if (!trig_ff) begin
                     trig_ff   <= 1'b1;
                     pend_ff   <= '0;
                     wstart_ff <= wr_ord_ff - pre_eff;
                     reason_ff <= tkind_ff;
                  end
                  wcount_ff    <= (win_n > Depth32) ? 11'(RING_DEPTH) : 11'(win_n);
                  post_left_ff <= post_dec;
                  if (post_dec == 11'd0) begin
                     armed_ff  <= 1'b0;
                     status_ff <= scr_pkg::ST_COMPLETE;
                  end
               end
               phase_ff <= P_RESP;
            end
            P_RDWAIT: phase_ff <= P_RDDATA;
            P_RDDATA: begin
               rv_ff     <= 1'b1;
               rd_ord_ff <= cur_ff + 32'd1;
               phase_ff  <= P_RESP;
            end
            P_RESP: begin
               rsp_valid_ff <= 1'b1;
               phase_ff     <= P_IDLE;
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   // read payload register
   logic [127:0] rchan;
   always_comb begin
      rchan = '0;
      rchan[32*NUM_CHANNELS-1:0] = mem_rdata[DW-1:65];
   end

   always_ff @(posedge clock) begin
      if (phase_ff == P_RDDATA) begin
         rg_ff    <= mem_rdata[0];
         rseq_ff  <= mem_rdata[32:1];
         rtime_ff <= mem_rdata[64:33];
         ra_ff    <= rchan[31:0];
         rb_ff    <= rchan[63:32];
         rc_ff    <= rchan[95:64];
         rd_ff    <= rchan[127:96];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_capture_status = status_ff;
   assign rsp_final_reason   = reason_ff;
   assign rsp_stored_count   = wcount_ff;
   assign rsp_overrun_count  = overruns_ff;
   assign rsp_read_valid     = rv_ff;
   assign rsp_read_gap       = rv_ff & rg_ff;
   assign rsp_read_sequence  = rv_ff ? rseq_ff : '0;
   assign rsp_read_time      = rv_ff ? rtime_ff : '0;
   assign rsp_read_a         = rv_ff ? ra_ff : '0;
   assign rsp_read_b         = rv_ff ? rb_ff : '0;
   assign rsp_read_c         = rv_ff ? rc_ff : '0;
   assign rsp_read_d         = rv_ff ? rd_ff : '0;

`include "scope_capture_trigger_ring_assert.svh"
   `SCR_ASSERT_IMPL(a_no_accept_busy, clock, reset, phase_ff != P_IDLE, !req_ready)
   `SCR_ASSERT_IMPL(a_mod_only_sample, clock, reset, mod_ctl.busy, phase_ff == P_MOD)
   `SCR_ASSERT_NEXT(a_write_advances, clock, reset, mem_we, phase_ff == P_RESP)
   `SCR_ASSERT_IMPL(a_window_bound, clock, reset, 1'b1, wcount_ff <= 11'(RING_DEPTH))
endmodule

>>> test/tb_scope_capture_trigger_ring.sv
`timescale 1ns / 100ps

module tb_scope_capture_trigger_ring;

   localparam int Depth = scr_pkg::RingDepthDefault;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  reason;
      logic [10:0] count;
      logic [31:0] overruns;
      logic        rvalid;
      logic        gap;
      logic [31:0] seq;
      logic [31:0] stamp;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } capture_result_type;

   // capture engine mirror plus queue of expected responses
   class capture_scoreboard;
      logic [31:0] ring_seq [Depth];
      logic [31:0] ring_stamp [Depth];
      logic        ring_gap [Depth];
      logic [31:0] ring_words [Depth][4];
      logic [31:0] wr_ord, rd_ord, win_start, win_count, overruns, post_left;
      logic [31:0] last_seq, prev_value;
      logic        have_last, have_prev, armed, triggered, cursor;
      logic [2:0]  pending;
      logic [7:0]  last_task;
      logic [1:0]  status;
      logic [2:0]  reason;
      logic        cfg_mode, cfg_edge;
      logic [2:0]  cfg_trig;
      logic [31:0] cfg_thr;
      logic [7:0]  cfg_match;
      logic [15:0] cfg_decim;
      logic [10:0] cfg_pre, cfg_post;
      capture_result_type expected_results[$];
      int failures;

      function new();
         wr_ord = 0; rd_ord = 0; win_start = 0; win_count = 0; overruns = 0;
         post_left = 0; last_seq = 0; prev_value = 0; have_last = 0; have_prev = 0;
         armed = 0; triggered = 0; cursor = 0; pending = 0; last_task = 0;
         status = scr_pkg::ST_IDLE; reason = scr_pkg::RS_NONE;
         cfg_mode = 0; cfg_edge = 0; cfg_trig = 0; cfg_thr = 0; cfg_match = 0;
         cfg_decim = 1; cfg_pre = 0; cfg_post = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            scr_pkg::REG_MODE:      cfg_mode = data[0];
            scr_pkg::REG_TRIG_KIND: cfg_trig = data[2:0];
            scr_pkg::REG_EDGE:      cfg_edge = data[0];
            scr_pkg::REG_THRESHOLD: cfg_thr = data;
            scr_pkg::REG_MATCH:     cfg_match = data[7:0];
            scr_pkg::REG_DECIM:     cfg_decim = data[15:0];
            scr_pkg::REG_PRE:       cfg_pre = data[10:0];
            default:                cfg_post = data[10:0];
         endcase
      endfunction

      // trigger evaluation, threshold history advances only here
      function logic trigger_hit(logic signed [31:0] cur);
         logic hit;
         hit = 0;
         case (cfg_trig)
            scr_pkg::TRIG_MANUAL: hit = pending[0];
            scr_pkg::TRIG_FAULT:  hit = pending[1];
            scr_pkg::TRIG_STATE:  hit = pending[2];
            scr_pkg::TRIG_THRESHOLD: begin
               if (cfg_edge)
                  hit = have_prev && ($signed(prev_value) > $signed(cfg_thr))
                        && (cur <= $signed(cfg_thr));
               else
                  hit = have_prev && ($signed(prev_value) < $signed(cfg_thr))
                        && (cur >= $signed(cfg_thr));
               prev_value = cur;
               have_prev = 1;
            end
            default: hit = 0;
         endcase
         return hit;
      endfunction

      function void store_sample(logic [31:0] seq, logic [31:0] stamp,
                                 logic [31:0] tv, logic [31:0] w [4]);
         logic [31:0] ord, pre, n, step;
         int slot;
         if (!armed) return;
         if (cfg_decim == 0 || (seq % cfg_decim) != 0) return;
         ord = wr_ord;
         if (!cfg_mode && (ord - rd_ord) >= Depth) overruns++;
         slot = ord % Depth;
         step = seq - last_seq;
         ring_seq[slot] = seq;
         ring_stamp[slot] = stamp;
         ring_gap[slot] = have_last && (step != {16'd0, cfg_decim});
         for (int i = 0; i < 4; i++) ring_words[slot][i] = w[i];
         wr_ord = ord + 1;
         last_seq = seq;
         have_last = 1;
         if (cfg_mode && !triggered && trigger_hit(tv)) begin
            pre = cfg_pre;
            if (pre > Depth - 1) pre = Depth - 1;
            if (pre > ord) pre = ord;
            triggered = 1;
            pending = 0;
            win_start = ord - pre;
            post_left = cfg_post;
            reason = cfg_trig;
         end
         if (!cfg_mode) begin
            win_count = (ord >= Depth - 1) ? Depth : ord + 1;
         end else if (triggered) begin
            n = ord + 1 - win_start;
            win_count = (n > Depth) ? Depth : n;
            if (post_left > 0) post_left--;
            if (post_left == 0) begin
               armed = 0;
               status = scr_pkg::ST_COMPLETE;
            end
         end
      endfunction

      function void fetch(ref capture_result_type r);
         logic [31:0] cur;
         int slot;
         if (status == scr_pkg::ST_IDLE) return;
         if (cfg_mode && status != scr_pkg::ST_COMPLETE) return;
         if (status == scr_pkg::ST_COMPLETE && !cursor) begin
            rd_ord = win_start;
            cursor = 1;
         end
         cur = rd_ord;
         if ((wr_ord - cur) > Depth) cur = wr_ord - Depth;
         if (wr_ord == cur) return;
         slot = cur % Depth;
         r.rvalid = 1;
         r.gap = ring_gap[slot];
         r.seq = ring_seq[slot];
         r.stamp = ring_stamp[slot];
         r.a = ring_words[slot][0];
         r.b = ring_words[slot][1];
         r.c = ring_words[slot][2];
         r.d = ring_words[slot][3];
         rd_ord = cur + 1;
      endfunction

      function void note_request(logic [2:0] kind, logic [31:0] seq, logic [31:0] stamp,
                                 logic [31:0] tv, logic [31:0] w [4], logic [7:0] ts);
         capture_result_type r;
         r = '0;
         case (kind)
            scr_pkg::KIND_SAMPLE: store_sample(seq, stamp, tv, w);
            scr_pkg::KIND_MANUAL:
               if (armed && cfg_trig == scr_pkg::TRIG_MANUAL) pending[0] = 1;
            scr_pkg::KIND_FAULT:  if (armed) pending[1] = 1;
            scr_pkg::KIND_STATE: begin
               if (ts != last_task && cfg_trig == scr_pkg::TRIG_STATE && ts == cfg_match)
                  pending[2] = 1;
               last_task = ts;
            end
            scr_pkg::KIND_ARM: begin
               wr_ord = 0; rd_ord = 0; win_start = 0; win_count = 0; overruns = 0;
               post_left = 0; last_seq = 0; have_last = 0; prev_value = 0;
               have_prev = 0; pending = 0;
               armed = 1; triggered = 0; cursor = 0;
               status = scr_pkg::ST_ARMED; reason = scr_pkg::RS_NONE;
            end
            scr_pkg::KIND_STOP: begin
               armed = 0;
               status = scr_pkg::ST_STOPPED;
               reason = scr_pkg::RS_STOPPED;
            end
            scr_pkg::KIND_READ: fetch(r);
            default: ;
         endcase
         r.status = status;
         r.reason = reason;
         r.count = win_count[10:0];
         r.overruns = overruns;
         expected_results.push_back(r);
      endfunction

      function void check_result(capture_result_type got);
         capture_result_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: response with none expected, got %h", $time, got);
            failures++;
            return;
         end
         e = expected_results.pop_front();
         if (got !== e) begin
            $write("%0t: mismatch expected st=%0d rs=%0d cnt=%0d ovr=%0d ",
                   $time, e.status, e.reason, e.count, e.overruns);
            $display("rv=%0d gap=%0d seq=%h t=%h %h %h %h %h",
                     e.rvalid, e.gap, e.seq, e.stamp, e.a, e.b, e.c, e.d);
            $write("%0t: mismatch actual   st=%0d rs=%0d cnt=%0d ovr=%0d ",
                   $time, got.status, got.reason, got.count, got.overruns);
            $display("rv=%0d gap=%0d seq=%h t=%h %h %h %h %h",
                     got.rvalid, got.gap, got.seq, got.stamp, got.a, got.b, got.c, got.d);
            failures++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid, req_ready;
   logic [2:0]  req_kind;
   logic [31:0] req_sample_sequence, req_sample_time;
   logic signed [31:0] req_trigger_value;
   logic [31:0] req_chan_a, req_chan_b, req_chan_c, req_chan_d;
   logic [7:0]  req_task_state;
   logic        rsp_valid, rsp_ready;
   capture_result_type rsp;

   capture_scoreboard sb;
   bit   no_idle;
   bit   hold_off;
   int   items;
   logic [31:0] seq_next;

   scope_capture_trigger_ring u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_sample_sequence(req_sample_sequence),
      .req_sample_time(req_sample_time), .req_trigger_value(req_trigger_value),
      .req_chan_a(req_chan_a), .req_chan_b(req_chan_b),
      .req_chan_c(req_chan_c), .req_chan_d(req_chan_d),
      .req_task_state(req_task_state),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_capture_status(rsp.status), .rsp_final_reason(rsp.reason),
      .rsp_stored_count(rsp.count), .rsp_overrun_count(rsp.overruns),
      .rsp_read_valid(rsp.rvalid), .rsp_read_gap(rsp.gap),
      .rsp_read_sequence(rsp.seq), .rsp_read_time(rsp.stamp),
      .rsp_read_a(rsp.a), .rsp_read_b(rsp.b), .rsp_read_c(rsp.c), .rsp_read_d(rsp.d)
   );

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp);
   end

   // response receiver with random stalls and one long hold-off
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         n = no_idle ? 0 : $urandom_range(0, 9);
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_request(logic [2:0] kind, logic [31:0] seq, logic [31:0] tv,
                               logic [7:0] ts);
      int gap;
      logic [31:0] w [4];
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      w[0] = $urandom; w[1] = $urandom; w[2] = $urandom; w[3] = $urandom;
      req_kind = kind;
      req_sample_sequence = seq;
      req_sample_time = $urandom;
      req_trigger_value = tv;
      req_chan_a = w[0]; req_chan_b = w[1]; req_chan_c = w[2]; req_chan_d = w[3];
      req_task_state = ts;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, seq, req_sample_time, tv, w, ts);
      items++;
      @(negedge clock);
   endtask

   // wait for all responses, then let the remainder unit go quiet
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic configure(logic mode, logic [2:0] trig, logic edge_fall,
                            logic [31:0] thr, logic [7:0] match, logic [15:0] dec,
                            logic [10:0] pre, logic [10:0] post);
      drain();
      write_csr(scr_pkg::REG_MODE, mode);
      write_csr(scr_pkg::REG_TRIG_KIND, trig);
      write_csr(scr_pkg::REG_EDGE, edge_fall);
      write_csr(scr_pkg::REG_THRESHOLD, thr);
      write_csr(scr_pkg::REG_MATCH, match);
      write_csr(scr_pkg::REG_DECIM, dec);
      write_csr(scr_pkg::REG_PRE, pre);
      write_csr(scr_pkg::REG_POST, post);
   endtask

   // sample with mostly in-order sequence, some gaps and off-grid numbers
   task automatic send_sample(logic [31:0] tv);
      int r;
      logic [31:0] seq;
      r = $urandom_range(0, 99);
      if (r < 85) seq = seq_next;
      else if (r < 95) seq = seq_next + sb.cfg_decim;
      else seq = $urandom;
      if (r < 95) seq_next = seq + sb.cfg_decim;
      send_request(scr_pkg::KIND_SAMPLE, seq, tv, 8'd0);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h8000_0000;
      if (r == 1) return 32'h7fff_ffff;
      if (r < 4) return $urandom;
      return sb.cfg_thr + $urandom_range(0, 40) - 20;
   endfunction

   task automatic run_phase(int n);
      int r;
      logic [7:0] ts;
      logic [31:0] k;
      k = $urandom_range(0, 1000);
      seq_next = ($urandom_range(0, 3) == 0) ? (32'hffff_fff0 / sb.cfg_decim) * sb.cfg_decim
                                             : k * sb.cfg_decim;
      no_idle = ($urandom_range(0, 4) == 0);
      send_request(scr_pkg::KIND_ARM, 0, 0, 0);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) send_sample(pick_value());
         else if (r < 80) send_request(scr_pkg::KIND_READ, $urandom, $urandom, $urandom);
         else if (r < 85) send_request(scr_pkg::KIND_MANUAL, $urandom, $urandom, $urandom);
         else if (r < 89) send_request(scr_pkg::KIND_FAULT, $urandom, $urandom, $urandom);
         else if (r < 96) begin
            ts = ($urandom_range(0, 1)) ? sb.cfg_match : 8'($urandom);
            send_request(scr_pkg::KIND_STATE, $urandom, $urandom, ts);
         end else if (r < 98) send_request(scr_pkg::KIND_STOP, $urandom, $urandom, $urandom);
         else send_request(scr_pkg::KIND_ARM, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      logic [15:0] dec;
      logic [10:0] pre, post;
      sb = new();
      items = 0;
      no_idle = 0;
      hold_off = 0;
      seq_next = 0;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_valid = 1'b0; req_kind = '0; req_sample_sequence = '0; req_sample_time = '0;
      req_trigger_value = '0; req_chan_a = '0; req_chan_b = '0; req_chan_c = '0;
      req_chan_d = '0; req_task_state = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: idle reads, stop, manual capture, state request, threshold trigger
      configure(1, scr_pkg::TRIG_MANUAL, 0, 0, 8'hff, 1, 2, 3);
      send_request(scr_pkg::KIND_READ, 0, 0, 0);
      send_request(scr_pkg::KIND_STOP, 0, 0, 0);
      send_request(scr_pkg::KIND_READ, 0, 0, 0);
      send_request(scr_pkg::KIND_ARM, 0, 0, 0);
      send_request(scr_pkg::KIND_STATE, 0, 0, 8'hff);
      for (int i = 0; i < 3; i++) send_request(scr_pkg::KIND_SAMPLE, i, 0, 0);
      send_request(scr_pkg::KIND_READ, 0, 0, 0);
      send_request(scr_pkg::KIND_MANUAL, 0, 0, 0);
      send_request(scr_pkg::KIND_SAMPLE, 32'hffff_ffff, 0, 0);
      for (int i = 3; i < 7; i++) send_request(scr_pkg::KIND_SAMPLE, i + (i == 5), 0, 0);
      for (int i = 0; i < 6; i++) send_request(scr_pkg::KIND_READ, 0, 0, 0);
      configure(1, scr_pkg::TRIG_THRESHOLD, 0, 32'h7fff_ffff, 0, 1, 11'd1024, 0);
      send_request(scr_pkg::KIND_ARM, 0, 0, 0);
      send_request(scr_pkg::KIND_SAMPLE, 0, 32'h8000_0000, 0);
      send_request(scr_pkg::KIND_SAMPLE, 1, 32'h7fff_ffff, 0);
      send_request(scr_pkg::KIND_READ, 0, 0, 0);

      // continuous stream overrunning the reader, with a long receiver stall
      configure(0, 3'd0, 0, 0, 0, 1, 0, 0);
      send_request(scr_pkg::KIND_ARM, 0, 0, 0);
      seq_next = 0;
      hold_off = 1;
      for (int i = 0; i < 1100; i++) begin
         if (i % 300 == 299) send_request(scr_pkg::KIND_READ, 0, 0, 0);
         else send_sample(0);
      end
      for (int i = 0; i < 4; i++) send_request(scr_pkg::KIND_READ, 0, 0, 0);

      // random settings, extremes included
      while (items < 1850) begin
         case ($urandom_range(0, 3))
            0: dec = 1;
            1: dec = 16'hffff;
            default: dec = $urandom_range(1, 5);
         endcase
         pre = ($urandom_range(0, 3) == 0) ? 11'd1024 : 11'($urandom_range(0, 12));
         case ($urandom_range(0, 7))
            0: post = 11'd1024;
            1: post = 0;
            default: post = 11'($urandom_range(1, 12));
         endcase
         configure($urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)),
                   $urandom_range(0, 1),
                   ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : 32'($urandom_range(0, 200)) - 100,
                   8'($urandom), dec, pre, post);
         run_phase($urandom_range(60, 140));
      end

      drain();
      if (sb.failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
